[rtl/core/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 11;
  localparam int DATA_W       = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Broadcast controls from the controller to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
    logic loc;
  } pal_ctrl_t;

  // Query token that walks the cell row one cell per cycle.
  typedef struct packed {
    logic              act;
    logic              hit;
    logic [DATA_W-1:0] data;
  } pal_tok_t;

endpackage

[rtl/core/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: shifts with its neighbors on insert and remove, and
// answers the query token as it passes by.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
  parameter  int CAPACITY = CAPACITY_DEF,
  parameter  int IDX      = 0,
  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pal_ctrl_t         ctrl,
  input  logic [IW-1:0]     idx,
  input  logic [CW-1:0]     cnt,
  input  logic [DATA_W-1:0] word,
  input  logic [DATA_W-1:0] left_ent,
  input  logic [DATA_W-1:0] right_ent,
  output logic [DATA_W-1:0] ent_o,
  input  pal_tok_t          tok_i,
  input  logic [CW-1:0]     fpos_i,
  output pal_tok_t          tok_o,
  output logic [CW-1:0]     fpos_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX + 1);

  logic [DATA_W-1:0] ent_r, ent_nxt;
  pal_tok_t          tok_r, tok_nxt;
  logic [CW-1:0]     fpos_r, fpos_nxt;
  logic              match;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (MY_IDX == idx) begin
        ent_nxt = word;
      end else if (MY_IDX > idx) begin
        ent_nxt = left_ent;
      end
    end
    if (ctrl.rem && (MY_IDX >= idx)) begin
      ent_nxt = right_ent;
    end
  end

  always_comb begin
    match    = ctrl.loc ? ((ent_r == word) && (MY_CNT < cnt)) : (MY_IDX == idx);
    tok_nxt  = tok_i;
    fpos_nxt = fpos_i;
    if (tok_i.act && !tok_i.hit && match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.data = ent_r;
      fpos_nxt     = MY_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.act <= 1'b0;
    end else begin
      tok_r.act <= tok_nxt.act;
    end
    tok_r.hit  <= tok_nxt.hit;
    tok_r.data <= tok_nxt.data;
    fpos_r     <= fpos_nxt;
    ent_r      <= ent_nxt;
  end

  assign ent_o  = ent_r;
  assign tok_o  = tok_r;
  assign fpos_o = fpos_r;

endmodule

[rtl/core/pal_chain.sv]
// ----------------------------------------------------------------------------
// pal_chain
// Row of CAPACITY cells; entry i sits in cell i, the token enters at cell 0.
// ----------------------------------------------------------------------------
module pal_chain import pal_pkg::*; #(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pal_ctrl_t         ctrl,
  input  logic [IW-1:0]     idx,
  input  logic [CW-1:0]     cnt,
  input  logic [DATA_W-1:0] word,
  input  pal_tok_t          tok_in,
  output pal_tok_t          tok_out,
  output logic [CW-1:0]     fpos_out
);

  logic [DATA_W-1:0] ent  [CAPACITY];
  pal_tok_t          tok  [CAPACITY];
  logic [CW-1:0]     fpos [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_ent, right_ent;
    pal_tok_t          tok_prev;
    logic [CW-1:0]     fpos_prev;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign tok_prev  = tok_in;
      assign fpos_prev = '0;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign tok_prev  = tok[i-1];
      assign fpos_prev = fpos[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    pal_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .idx       (idx),
      .cnt       (cnt),
      .word      (word),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent_o     (ent[i]),
      .tok_i     (tok_prev),
      .fpos_i    (fpos_prev),
      .tok_o     (tok[i]),
      .fpos_o    (fpos[i])
    );
  end

  assign tok_out  = tok[CAPACITY-1];
  assign fpos_out = fpos[CAPACITY-1];

endmodule

[rtl/core/positional_array_list_unit.sv]
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of up to CAPACITY words addressed by 1-based position.
//
//   channel | dir | tdata (low bit up)                 | tuser (low bit up)
//   in_     | in  | position[10:0], value[31:0]        | cmd[2:0]
//   out_    | out | data_out, found_position, count    | ok, is_empty
//
// Insert, clear and rejected commands go from accept straight to the hold state.
// Read, remove and locate send a token down the cell row, one cell a cycle,
// and the result is taken from the last cell into the hold state.
// One item is in work at a time; the next is taken once the result has moved
// to the output register, which may still be waiting on out_tready.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_array_list_unit import pal_pkg::*; #(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[10:0], value[42:11]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // data_out[31:0], found_position[42:32], count[53:43]
  output logic [1:0]  out_tuser   // ok[0], is_empty[1]
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_HOLD} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic [CW-1:0]     res_fpos_r, res_fpos_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W-1:0]  out_fpos_r, out_fpos_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [POS_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;
  logic              in_acc;
  logic [CMPW-1:0]   pos_x, cnt_x, fpos_x, cntn_x;
  logic [IW-1:0]     idx_in;
  logic              rd_ok, ins_ok, out_free;

  pal_ctrl_t         ctrl;
  logic [IW-1:0]     chain_idx;
  logic [DATA_W-1:0] chain_word;
  pal_tok_t          tok_in, tok_last;
  logic [CW-1:0]     fpos_last;

  assign in_cmd   = in_tuser[CMD_W-1:0];
  assign in_pos   = in_tdata[POS_W-1:0];
  assign in_value = in_tdata[POS_W+DATA_W-1:POS_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign pos_x  = CMPW'(in_pos);
  assign cnt_x  = CMPW'(cnt_r);
  assign idx_in = IW'(pos_x - CMPW'(1));
  assign rd_ok  = (in_pos != '0) && (pos_x <= cnt_x);
  assign ins_ok = (cnt_r != CAP_CNT) && (in_pos != '0) &&
                  (CMPW'(pos_x - CMPW'(1)) <= cnt_x);
  assign out_free = !out_valid_r || out_tready;

  assign fpos_x = CMPW'(res_fpos_r);
  assign cntn_x = CMPW'(cnt_r);

  assign chain_idx  = (state_r == S_IDLE) ? idx_in : idx_r;
  assign chain_word = (state_r == S_IDLE) ? in_value : key_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    res_data_nxt  = res_data_r;
    res_fpos_nxt  = res_fpos_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_fpos_nxt  = out_fpos_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    ctrl          = '0;
    tok_in        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_cmd;
          idx_nxt      = idx_in;
          key_nxt      = in_value;
          res_data_nxt = '0;
          res_fpos_nxt = '0;
          res_ok_nxt   = 1'b0;
          state_nxt    = S_HOLD;
          unique case (in_cmd) inside
            CMD_INSERT: begin
              if (ins_ok) begin
                ctrl.ins   = 1'b1;
                cnt_nxt    = cnt_r + CW'(1);
                res_ok_nxt = 1'b1;
              end
            end
            CMD_REMOVE, CMD_READ: begin
              if (rd_ok) begin
                tok_in.act = 1'b1;
                state_nxt  = S_SWEEP;
              end
            end
            CMD_LOCATE: begin
              ctrl.loc   = 1'b1;
              tok_in.act = 1'b1;
              state_nxt  = S_SWEEP;
            end
            CMD_CLEAR: begin
              cnt_nxt    = '0;
              res_ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        ctrl.loc = (op_r == CMD_LOCATE);
        if (tok_last.act) begin
          state_nxt = S_HOLD;
          if (op_r == CMD_LOCATE) begin
            res_data_nxt = '0;
            res_fpos_nxt = fpos_last;
            res_ok_nxt   = tok_last.hit;
          end else begin
            res_data_nxt = tok_last.data;
            res_fpos_nxt = '0;
            res_ok_nxt   = 1'b1;
            if (op_r == CMD_REMOVE) begin
              ctrl.rem = 1'b1;
              cnt_nxt  = cnt_r - CW'(1);
            end
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_fpos_nxt  = fpos_x[POS_W-1:0];
          out_ok_nxt    = res_ok_r;
          out_cnt_nxt   = cntn_x[POS_W-1:0];
          out_empty_nxt = (cnt_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    res_data_r  <= res_data_nxt;
    res_fpos_r  <= res_fpos_nxt;
    res_ok_r    <= res_ok_nxt;
    out_data_r  <= out_data_nxt;
    out_fpos_r  <= out_fpos_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
  end

  pal_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .idx      (chain_idx),
    .cnt      (cnt_r),
    .word     (chain_word),
    .tok_in   (tok_in),
    .tok_out  (tok_last),
    .fpos_out (fpos_last)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_fpos_r, out_data_r};
  assign out_tuser  = {out_empty_r, out_ok_r};

`ifndef SYNTH
  a_no_token_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SWEEP) |-> !tok_last.act)
    else $error("token left the cell row outside a sweep");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_insert_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_INSERT) && (cnt_r == CAP_CNT)) |=>
    ($stable(cnt_r) && !res_ok_r))
    else $error("insert into a full list changed the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_CLEAR)) |=> (cnt_r == '0))
    else $error("clear left entries in the list");

  a_remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && tok_last.act && (op_r == CMD_REMOVE)) |=>
    (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("remove did not drop the count by one");
`endif

endmodule
